### src/mcc_pkg.sv
// Shared types and constants of the minimum coin change block.
package mcc_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int CNT_W     = 13;
  localparam int SLOT_W    = 2;
  localparam int AMT_MAX   = 8191;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef count_t [NUM_SLOTS-1:0] coin_arr_t;

  // One table entry: reachability, least count and the slot taken last.
  typedef struct packed {
    logic   reach;
    count_t count;
    slot_t  slot;
  } entry_t;

  // Finished answer handed from the engine to the result sequencer.
  typedef struct packed {
    logic      ok;
    count_t    total;
    coin_arr_t tally;
  } res_t;

endpackage

### src/min_coin_change_top.sv
// Top level of the minimum coin change block.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  amount_i
//   out      output     out_valid_o/out_stall_i coin_slot_o, coin_count_o,
//                                               total_coins_o, reachable_o, last_o
//   cfg      input      APB psel/penable       coin values 0..3 at 0x0, 0x4, 0x8, 0xC
//
// For amount A the engine fills the table entry by entry, with at most one
// memory read per coin slot and one write per amount, then walks back from A
// reading one table entry per step, then hands the answer off.
// The fill loop through the table memory takes most of a request's time.
// The input is stalled for the whole request; the next word is taken once the
// answer has moved into the output stage, so results may still be draining.
// Reset is asynchronous and active low; the table needs no clearing pass because
// every request rewrites the entries it reads.
// A stall on the output holds the current word; the four words of one answer
// leave in slot order.
module min_coin_change_top
  import mcc_pkg::*;
#(
  parameter int MAX_AMOUNT = 8191,
  parameter int NUM_COINS  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CNT_W-1:0]  amount_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SLOT_W-1:0] coin_slot_o,
  output logic [CNT_W-1:0]  coin_count_o,
  output logic [CNT_W-1:0]  total_coins_o,
  output logic              reachable_o,
  output logic              last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  coin_arr_t coin;
  logic      busy, res_vld, res_rdy, start;
  res_t      res;

  // The engine only ever leaves idle on an accepted word.
  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  mcc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coin_o  (coin)
  );

  mcc_engine #(
    .MAX_AMOUNT (MAX_AMOUNT),
    .NUM_COINS  (NUM_COINS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .amount_i  (amount_i),
    .coin_i    (coin),
    .busy_o    (busy),
    .res_vld_o (res_vld),
    .res_rdy_i (res_rdy),
    .res_o     (res)
  );

  mcc_emit #(
    .NUM_COINS (NUM_COINS)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_vld_i     (res_vld),
    .res_rdy_o     (res_rdy),
    .res_i         (res),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .coin_slot_o   (coin_slot_o),
    .coin_count_o  (coin_count_o),
    .total_coins_o (total_coins_o),
    .reachable_o   (reachable_o),
    .last_o        (last_o)
  );

endmodule

### src/mcc_apb_regs.sv
// APB register file that holds the four coin values.
module mcc_apb_regs
  import mcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output coin_arr_t         coin_o
);

  coin_arr_t coin_q;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign prdata = {{(APB_DW-CNT_W){1'b0}}, coin_q[idx]};
  assign coin_o = coin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      coin_q[idx] <= pwdata[CNT_W-1:0];
    end
  end

endmodule

### src/mcc_engine.sv
// Table fill and walk back sequencer around one shared subtract and compare unit.
module mcc_engine
  import mcc_pkg::*;
#(
  parameter int MAX_AMOUNT = 8191,
  parameter int NUM_COINS  = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  count_t    amount_i,
  input  coin_arr_t coin_i,
  output logic      busy_o,
  output logic      res_vld_o,
  input  logic      res_rdy_i,
  output res_t      res_o
);

  localparam int CAP   = (MAX_AMOUNT < AMT_MAX) ? MAX_AMOUNT : AMT_MAX;
  localparam int DEPTH = CAP + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(NUM_COINS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_WRD  = 3'd2;
  localparam logic [2:0] ST_WEV  = 3'd3;
  localparam logic [2:0] ST_HAND = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] amt_q, amt_d, i_q, i_d, a_q, a_d;
  logic [KW-1:0] k_q, k_d;
  logic          rd_vld_q, rd_vld_d, have_q, have_d, first_q, first_d;
  count_t        best_q, best_d;
  slot_t         pick_q, pick_d, rk_q, rk_d;
  logic          ok_q, ok_d;
  count_t        total_q, total_d;
  coin_arr_t     tally_q, tally_d;
  entry_t        rdata_q;

  entry_t        mem [DEPTH];

  // Shared unit signals.
  slot_t         sel_slot;
  logic [AW-1:0] opnd;
  count_t        coin;
  logic [13:0]   diff;
  logic          coin_ok;

  // Candidate evaluation of the word read in the previous cycle.
  count_t        cand;
  logic          win, have_n;
  count_t        best_n;
  slot_t         pick_n;

  logic          last_k;
  logic          rd_en, we;
  logic [AW-1:0] raddr, waddr;
  entry_t        wdata;
  logic          small_amt;

  assign small_amt = int'(amount_i) <= CAP;
  assign last_k    = k_q == KW'(NUM_COINS);

  always_comb begin
    sel_slot = (state_q == ST_FILL) ? SLOT_W'(k_q) : rdata_q.slot;
    opnd     = (state_q == ST_FILL) ? i_q : a_q;
    coin     = coin_i[sel_slot];
    diff     = 14'(opnd) - 14'(coin);
    coin_ok  = (coin != '0) && !diff[13];
  end

  always_comb begin
    cand   = rdata_q.count + 13'd1;
    win    = rd_vld_q && rdata_q.reach && (!have_q || cand <= best_q);
    have_n = have_q || win;
    best_n = win ? cand : best_q;
    pick_n = win ? rk_q : pick_q;
  end

  always_comb begin
    rd_en = ((state_q == ST_FILL) && !last_k && coin_ok) || (state_q == ST_WRD);
    raddr = (state_q == ST_FILL) ? diff[AW-1:0] : a_q;
    we    = (start_i && small_amt) || ((state_q == ST_FILL) && last_k);
    waddr = start_i ? '0 : i_q;
    if (start_i) begin
      wdata = '{reach: 1'b1, count: '0, slot: '0};
    end else begin
      wdata = '{reach: have_n, count: have_n ? best_n : '0, slot: have_n ? pick_n : '0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    state_d  = state_q;
    amt_d    = amt_q;
    i_d      = i_q;
    a_d      = a_q;
    k_d      = k_q;
    rd_vld_d = rd_vld_q;
    have_d   = have_q;
    best_d   = best_q;
    pick_d   = pick_q;
    rk_d     = rk_q;
    first_d  = first_q;
    ok_d     = ok_q;
    total_d  = total_q;
    tally_d  = tally_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          tally_d  = '0;
          ok_d     = 1'b0;
          total_d  = '0;
          have_d   = 1'b0;
          rd_vld_d = 1'b0;
          k_d      = '0;
          first_d  = 1'b1;
          amt_d    = amount_i[AW-1:0];
          a_d      = amount_i[AW-1:0];
          i_d      = AW'(1);
          if (!small_amt) begin
            state_d = ST_HAND;
          end else if (amount_i == '0) begin
            state_d = ST_WRD;
          end else begin
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (last_k) begin
          have_d   = 1'b0;
          rd_vld_d = 1'b0;
          k_d      = '0;
          if (i_q == amt_q) begin
            a_d     = amt_q;
            state_d = ST_WRD;
          end else begin
            i_d = i_q + AW'(1);
          end
        end else begin
          have_d   = have_n;
          best_d   = best_n;
          pick_d   = pick_n;
          rd_vld_d = coin_ok;
          rk_d     = sel_slot;
          k_d      = k_q + KW'(1);
        end
      end
      ST_WRD: begin
        state_d = ST_WEV;
      end
      ST_WEV: begin
        first_d = 1'b0;
        if (first_q) begin
          ok_d    = rdata_q.reach;
          total_d = rdata_q.reach ? rdata_q.count : '0;
        end
        if ((first_q && !rdata_q.reach) || (a_q == '0) || !coin_ok) begin
          state_d = ST_HAND;
        end else begin
          tally_d[rdata_q.slot] = tally_q[rdata_q.slot] + 13'd1;
          a_d     = diff[AW-1:0];
          state_d = ST_WRD;
        end
      end
      ST_HAND: begin
        if (res_rdy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      have_q   <= 1'b0;
      first_q  <= 1'b0;
      k_q      <= '0;
      ok_q     <= 1'b0;
      total_q  <= '0;
      tally_q  <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      have_q   <= have_d;
      first_q  <= first_d;
      k_q      <= k_d;
      ok_q     <= ok_d;
      total_q  <= total_d;
      tally_q  <= tally_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q  <= amt_d;
    i_q    <= i_d;
    a_q    <= a_d;
    best_q <= best_d;
    pick_q <= pick_d;
    rk_q   <= rk_d;
  end

  assign busy_o    = state_q != ST_IDLE;
  assign res_vld_o = state_q == ST_HAND;
  assign res_o     = '{ok: ok_q, total: total_q, tally: tally_q};

endmodule

### src/mcc_emit.sv
// Output register stage that sends one word per coin slot.
module mcc_emit
  import mcc_pkg::*;
#(
  parameter int NUM_COINS = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   res_vld_i,
  output logic   res_rdy_o,
  input  res_t   res_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output slot_t  coin_slot_o,
  output count_t coin_count_o,
  output count_t total_coins_o,
  output logic   reachable_o,
  output logic   last_o
);

  logic  busy_q;
  slot_t slot_q;
  res_t  res_q;
  logic  is_last;

  assign is_last   = slot_q == SLOT_W'(NUM_COINS - 1);
  assign res_rdy_o = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
    end else if (!busy_q) begin
      if (res_vld_i) begin
        busy_q <= 1'b1;
        slot_q <= '0;
      end
    end else if (!out_stall_i) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        slot_q <= slot_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = busy_q;
  assign coin_slot_o   = slot_q;
  assign coin_count_o  = res_q.tally[slot_q];
  assign total_coins_o = res_q.total;
  assign reachable_o   = res_q.ok;
  assign last_o        = is_last;

endmodule

### src/mcc_checker.sv
// Port-level checker of the minimum coin change block and its bind.
module mcc_checker
  import mcc_pkg::*;
#(
  parameter int NUM_COINS = 4
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [SLOT_W-1:0] coin_slot_o,
  input logic [CNT_W-1:0]  coin_count_o,
  input logic [CNT_W-1:0]  total_coins_o,
  input logic              reachable_o,
  input logic              last_o
);

  // A stalled output word stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coin_slot_o)
      && $stable(coin_count_o) && $stable(total_coins_o)
      && $stable(reachable_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // An unreachable answer carries no counts.
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o |-> coin_count_o == '0 && total_coins_o == '0)
    else $error("unreachable answer with nonzero counts");

  // The last flag marks exactly the highest used slot.
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_o == (coin_slot_o == SLOT_W'(NUM_COINS - 1)))
    else $error("last flag does not match slot");

  // An accepted request keeps the input stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a request");

endmodule

bind min_coin_change_top mcc_checker #(
  .NUM_COINS (NUM_COINS)
) u_mcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .coin_slot_o   (coin_slot_o),
  .coin_count_o  (coin_count_o),
  .total_coins_o (total_coins_o),
  .reachable_o   (reachable_o),
  .last_o        (last_o)
);
